// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/snh_pkg.sv
// Shared constants, types, saturating add/subtract and rounding helpers.
`default_nettype none
package snh_pkg;

  localparam int FRAC       = 24;
  localparam int MOD_FRAC   = 16;
  localparam int RATIO_FRAC = 24;
  localparam int MUL_LAT    = 4;
  localparam int PIPE_LAT   = 4 * MUL_LAT + 2;

  typedef logic signed [63:0] word_t;

  localparam word_t ONE   = word_t'(64'd1 << FRAC);
  localparam word_t THREE = word_t'(64'd3 << FRAC);
  localparam word_t W_MAX = word_t'({1'b0, {63{1'b1}}});
  localparam word_t W_MIN = word_t'({1'b1, {63{1'b0}}});

  localparam logic [5:0] SH_F   = 6'(FRAC);
  localparam logic [5:0] SH_MOD = 6'(MOD_FRAC);

  localparam logic [1:0] REG_SHEAR  = 2'd0;
  localparam logic [1:0] REG_VOLUME = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? W_MIN : W_MAX;
    return word_t'(s[63:0]);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? W_MIN : W_MAX;
    return word_t'(s[63:0]);
  endfunction

  // Nonnegative value with 'from' fraction bits to FRAC bits, rounded.
  function automatic word_t rescale(input logic [63:0] v, input int from);
    if (FRAC >= from) return word_t'(v << (FRAC - from));
    return word_t'((v + (64'd1 << (from - FRAC - 1))) >> (from - FRAC));
  endfunction

  // Halve, rounding ties away from zero.
  function automatic word_t halve(input word_t x);
    if (x[63]) return word_t'({x[63], x[63:1]});
    return word_t'({1'b0, x[63:1]} + {63'd0, x[0]});
  endfunction

endpackage
`default_nettype wire

// File: design/snh_mul.sv
// Pipelined signed 64x64 multiply, rounding right shift and saturation.
`default_nettype none
module snh_mul import snh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       ce,
  input  wire word_t      a,
  input  wire word_t      b,
  input  wire logic [5:0] sh,
  output word_t           p
);

  logic [63:0]  ua, ub;
  logic         neg1, neg2, neg3;
  logic [63:0]  pp00, pp01, pp10, pp11;
  logic [127:0] prod;
  logic [127:0] half, rnd;
  logic [63:0]  limit;
  logic         over;

  always_ff @(posedge clk) begin
    if (ce) begin
      ua   <= a[63] ? 64'(-a) : 64'(a);
      ub   <= b[63] ? 64'(-b) : 64'(b);
      neg1 <= a[63] ^ b[63];
      pp00 <= ua[31:0]  * ub[31:0];
      pp01 <= ua[31:0]  * ub[63:32];
      pp10 <= ua[63:32] * ub[31:0];
      pp11 <= ua[63:32] * ub[63:32];
      neg2 <= neg1;
      prod <= {64'd0, pp00} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0} + {pp11, 64'd0};
      neg3 <= neg2;
      if (over) p <= neg3 ? W_MIN : W_MAX;
      else      p <= neg3 ? word_t'(-rnd[63:0]) : word_t'(rnd[63:0]);
    end
  end

  always_comb begin
    half  = (sh == 6'd0) ? 128'd0 : (128'd1 << 6'(sh - 6'd1));
    rnd   = (prod + half) >> sh;
    limit = neg3 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    over  = (rnd[127:64] != 64'd0) || (rnd[63:0] > limit);
  end

endmodule
`default_nettype wire

// File: design/snh_dly.sv
// Fixed delay line matching the multiplier latency.
`default_nettype none
module snh_dly import snh_pkg::*; (
  input  wire logic  clk,
  input  wire logic  ce,
  input  wire word_t d,
  output word_t      q
);

  word_t sr [MUL_LAT];

  always_ff @(posedge clk) begin
    if (ce) begin
      sr[0] <= d;
      for (int k = 1; k < MUL_LAT; k++) sr[k] <= sr[k-1];
    end
  end

  assign q = sr[MUL_LAT-1];

endmodule
`default_nettype wire

// File: design/stable_neohookean_stretch_energy.sv
// Top level: stable neo-Hookean energy, gradient and Hessian pipeline.
// Fully pipelined: one stretch triple per cycle. The depth is four chained levels
// of 4-stage 64x64 multipliers plus a sum stage and the output register. When
// the output is held, the whole pipeline stalls. Config writes must happen only
// while the pipeline is empty.
`default_nettype none
`include "assert_macros.svh"
module stable_neohookean_stretch_energy import snh_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] stretch_a,
  input  wire logic signed [31:0] stretch_b,
  input  wire logic signed [31:0] stretch_c,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      energy,
  output logic signed [63:0]      grad_a,
  output logic signed [63:0]      grad_b,
  output logic signed [63:0]      grad_c,
  output logic signed [63:0]      hess_aa,
  output logic signed [63:0]      hess_bb,
  output logic signed [63:0]      hess_cc,
  output logic signed [63:0]      hess_ab,
  output logic signed [63:0]      hess_ac,
  output logic signed [63:0]      hess_bc
);

  logic [47:0] shear_modulus, volume_modulus;
  logic [31:0] rest_offset;
  logic [PIPE_LAT-1:0] vld;
  logic ce, stall;

  word_t mu_w, lam_w, r_w, mu_f;
  word_t s_in [3], s_l1 [3], s_l2 [3], s_l3 [3];
  word_t dj [3], dj_l2 [3], dj_l3 [3];
  word_t sq [3], gm [3], gm_d1 [3], gm_d2 [3], gm_d3 [3];
  word_t rr, j, musq, eb, musq_d1, musq_d2, eb_d1, eb_d2;
  word_t ldj [3], sq_sum, jm1, lj, jj, lamjj;
  word_t hd [3], ho [3], hd_d [3], ho_d [3], ljd [3], ljs [3];
  word_t grad_e [3], hdia_e [3], hoff_e [3], ea_e, eb_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      shear_modulus  <= 48'd65536;
      volume_modulus <= 48'd131072;
      rest_offset    <= 32'd8388608;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHEAR:  shear_modulus  <= cfg_data;
        REG_VOLUME: volume_modulus <= cfg_data;
        REG_OFFSET: rest_offset    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign stall     = vld[PIPE_LAT-1] & ~out_ready;
  assign ce        = ~stall;
  assign in_ready  = ce;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (ce) vld <= {vld[PIPE_LAT-2:0], in_valid};
  end

  // The user must keep the registers static while items are in flight; the block does not enforce it.
  assign mu_w  = word_t'({16'd0, shear_modulus});
  assign lam_w = word_t'({16'd0, volume_modulus});
  assign r_w   = rescale({32'd0, rest_offset}, RATIO_FRAC);
  assign mu_f  = rescale({16'd0, shear_modulus}, MOD_FRAC);

  assign s_in[0] = word_t'(stretch_a);
  assign s_in[1] = word_t'(stretch_b);
  assign s_in[2] = word_t'(stretch_c);

  assign sq_sum = sat_sub(sat_add(sat_add(sq[0], sq[1]), sq[2]), THREE);
  assign jm1    = sat_sub(sat_sub(j, ONE), r_w);

  // level A
  snh_mul u_dj0 (.clk, .ce, .a(s_in[1]), .b(s_in[2]), .sh(SH_F), .p(dj[0]));
  snh_mul u_dj1 (.clk, .ce, .a(s_in[0]), .b(s_in[2]), .sh(SH_F), .p(dj[1]));
  snh_mul u_dj2 (.clk, .ce, .a(s_in[0]), .b(s_in[1]), .sh(SH_F), .p(dj[2]));
  snh_mul u_rr  (.clk, .ce, .a(r_w), .b(r_w), .sh(SH_F), .p(rr));

  // level B
  snh_mul u_j    (.clk, .ce, .a(dj[2]), .b(s_l1[2]), .sh(SH_F), .p(j));
  snh_mul u_musq (.clk, .ce, .a(mu_w), .b(sq_sum), .sh(SH_MOD), .p(musq));
  snh_mul u_eb   (.clk, .ce, .a(lam_w), .b(rr), .sh(SH_MOD), .p(eb));
  snh_dly u_mq1  (.clk, .ce, .d(musq), .q(musq_d1));
  snh_dly u_mq2  (.clk, .ce, .d(musq_d1), .q(musq_d2));
  snh_dly u_eb1  (.clk, .ce, .d(eb), .q(eb_d1));
  snh_dly u_eb2  (.clk, .ce, .d(eb_d1), .q(eb_d2));

  // level C
  snh_mul u_lj (.clk, .ce, .a(lam_w), .b(jm1), .sh(SH_MOD), .p(lj));
  snh_mul u_jj (.clk, .ce, .a(jm1), .b(jm1), .sh(SH_F), .p(jj));

  // level D
  snh_mul u_lamjj (.clk, .ce, .a(lam_w), .b(jj), .sh(SH_MOD), .p(lamjj));

  for (genvar i = 0; i < 3; i++) begin : g_lane
    snh_mul u_sq  (.clk, .ce, .a(s_in[i]), .b(s_in[i]), .sh(SH_F), .p(sq[i]));
    snh_mul u_gm  (.clk, .ce, .a(mu_w), .b(s_in[i]), .sh(SH_MOD), .p(gm[i]));
    snh_dly u_s1  (.clk, .ce, .d(s_in[i]), .q(s_l1[i]));
    snh_dly u_s2  (.clk, .ce, .d(s_l1[i]), .q(s_l2[i]));
    snh_dly u_s3  (.clk, .ce, .d(s_l2[i]), .q(s_l3[i]));
    snh_dly u_g1  (.clk, .ce, .d(gm[i]), .q(gm_d1[i]));
    snh_dly u_g2  (.clk, .ce, .d(gm_d1[i]), .q(gm_d2[i]));
    snh_dly u_g3  (.clk, .ce, .d(gm_d2[i]), .q(gm_d3[i]));
    snh_dly u_d2  (.clk, .ce, .d(dj[i]), .q(dj_l2[i]));
    snh_dly u_d3  (.clk, .ce, .d(dj_l2[i]), .q(dj_l3[i]));
    snh_mul u_ldj (.clk, .ce, .a(lam_w), .b(dj[i]), .sh(SH_MOD), .p(ldj[i]));
    snh_mul u_hd  (.clk, .ce, .a(ldj[i]), .b(dj_l2[i]), .sh(SH_F), .p(hd[i]));
    // off-diagonal lanes: ab, ac, bc
    snh_mul u_ho  (.clk, .ce, .a(ldj[(i == 2) ? 1 : 0]), .b(dj_l2[(i == 0) ? 1 : 2]),
                   .sh(SH_F), .p(ho[i]));
    snh_dly u_hdd (.clk, .ce, .d(hd[i]), .q(hd_d[i]));
    snh_dly u_hod (.clk, .ce, .d(ho[i]), .q(ho_d[i]));
    snh_mul u_ljd (.clk, .ce, .a(lj), .b(dj_l3[i]), .sh(SH_F), .p(ljd[i]));
    snh_mul u_ljs (.clk, .ce, .a(lj), .b(s_l3[2-i]), .sh(SH_F), .p(ljs[i]));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        grad_e[i] <= sat_add(gm_d3[i], ljd[i]);
        hdia_e[i] <= sat_add(mu_f, hd_d[i]);
        hoff_e[i] <= sat_add(ho_d[i], ljs[i]);
      end
      ea_e    <= sat_add(musq_d2, lamjj);
      eb_e    <= eb_d2;
      energy  <= halve(sat_sub(ea_e, eb_e));
      grad_a  <= grad_e[0];
      grad_b  <= grad_e[1];
      grad_c  <= grad_e[2];
      hess_aa <= hdia_e[0];
      hess_bb <= hdia_e[1];
      hess_cc <= hdia_e[2];
      hess_ab <= hoff_e[0];
      hess_ac <= hoff_e[1];
      hess_bc <= hoff_e[2];
    end
  end

  `ASSERT_NEXT(a_stall_hold, clk, rst, stall, $stable(vld), "valid bits moved during stall")
  `ASSERT_NEXT(a_take_in, clk, rst, in_valid && in_ready, vld[0], "input transfer lost")
  `ASSERT_NEXT(a_advance, clk, rst, !stall, out_valid == $past(vld[PIPE_LAT-2]),
               "output stage did not advance")

endmodule
`default_nettype wire

// File: tb/stable_neohookean_stretch_energy_test.sv
// Testbench for the stable neo-Hookean stretch energy pipeline.
`timescale 1ns / 1ps
module stable_neohookean_stretch_energy_test import snh_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    word_t energy;
    word_t grad_a, grad_b, grad_c;
    word_t hess_aa, hess_bb, hess_cc;
    word_t hess_ab, hess_ac, hess_bc;
  } energy_result_t;

  class energy_scoreboard;
    logic [47:0] shear;
    logic [47:0] volume;
    logic [31:0] offset;
    energy_result_t pending[$];
    int errors;

    function new();
      shear = 48'd65536;
      volume = 48'd131072;
      offset = 32'd8388608;
      errors = 0;
    endfunction

    // Exact product, scaled down with round half away from zero, saturated.
    static function word_t mul_round(word_t a, word_t b, int sh);
      logic signed [127:0] p;
      logic [127:0] m;
      logic neg;
      p = 128'(a) * 128'(b);
      neg = p[127];
      m = neg ? -p : p;
      if (sh > 0) m = (m + (128'd1 << (sh - 1))) >> sh;
      if (!neg && m > 128'h7FFF_FFFF_FFFF_FFFF) return W_MAX;
      if (neg && m > 128'h8000_0000_0000_0000) return W_MIN;
      return neg ? word_t'(-m[63:0]) : word_t'(m[63:0]);
    endfunction

    static function word_t add_clip(word_t a, word_t b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return W_MAX;
      if (s < -65'sh0_8000_0000_0000_0000) return W_MIN;
      return s[63:0];
    endfunction

    static function word_t sub_clip(word_t a, word_t b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return W_MAX;
      if (s < -65'sh0_8000_0000_0000_0000) return W_MIN;
      return s[63:0];
    endfunction

    function void note(logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c);
      word_t s[3], dj[3], ldj[3];
      word_t mu, lam, j, r, jm1, lj, sq, e_a, e_b, mu_f;
      energy_result_t res;
      s[0] = 64'(a);
      s[1] = 64'(b);
      s[2] = 64'(c);
      mu = word_t'({16'd0, shear});
      lam = word_t'({16'd0, volume});
      dj[0] = mul_round(s[1], s[2], FRAC);
      dj[1] = mul_round(s[0], s[2], FRAC);
      dj[2] = mul_round(s[0], s[1], FRAC);
      j = mul_round(dj[2], s[2], FRAC);
      r = mul_round(word_t'({32'd0, offset}), ONE, RATIO_FRAC);
      jm1 = sub_clip(sub_clip(j, ONE), r);
      lj = mul_round(lam, jm1, MOD_FRAC);
      sq = add_clip(add_clip(mul_round(s[0], s[0], FRAC), mul_round(s[1], s[1], FRAC)),
                    mul_round(s[2], s[2], FRAC));
      sq = sub_clip(sq, THREE);
      e_a = add_clip(mul_round(mu, sq, MOD_FRAC),
                     mul_round(lam, mul_round(jm1, jm1, FRAC), MOD_FRAC));
      e_b = mul_round(lam, mul_round(r, r, FRAC), MOD_FRAC);
      res.energy = mul_round(sub_clip(e_a, e_b), 64'sd1, 1);
      for (int i = 0; i < 3; i++) ldj[i] = mul_round(lam, dj[i], MOD_FRAC);
      res.grad_a = add_clip(mul_round(mu, s[0], MOD_FRAC), mul_round(lj, dj[0], FRAC));
      res.grad_b = add_clip(mul_round(mu, s[1], MOD_FRAC), mul_round(lj, dj[1], FRAC));
      res.grad_c = add_clip(mul_round(mu, s[2], MOD_FRAC), mul_round(lj, dj[2], FRAC));
      mu_f = mul_round(mu, ONE, MOD_FRAC);
      res.hess_aa = add_clip(mu_f, mul_round(ldj[0], dj[0], FRAC));
      res.hess_bb = add_clip(mu_f, mul_round(ldj[1], dj[1], FRAC));
      res.hess_cc = add_clip(mu_f, mul_round(ldj[2], dj[2], FRAC));
      res.hess_ab = add_clip(mul_round(ldj[0], dj[1], FRAC), mul_round(lj, s[2], FRAC));
      res.hess_ac = add_clip(mul_round(ldj[0], dj[2], FRAC), mul_round(lj, s[1], FRAC));
      res.hess_bc = add_clip(mul_round(ldj[1], dj[2], FRAC), mul_round(lj, s[0], FRAC));
      pending.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare(string field, word_t got, word_t want);
      if (got !== want) report($sformatf("%s got %h want %h", field, got, want));
    endtask

    task check(energy_result_t got);
      energy_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      want = pending.pop_front();
      compare("energy", got.energy, want.energy);
      compare("grad_a", got.grad_a, want.grad_a);
      compare("grad_b", got.grad_b, want.grad_b);
      compare("grad_c", got.grad_c, want.grad_c);
      compare("hess_aa", got.hess_aa, want.hess_aa);
      compare("hess_bb", got.hess_bb, want.hess_bb);
      compare("hess_cc", got.hess_cc, want.hess_cc);
      compare("hess_ab", got.hess_ab, want.hess_ab);
      compare("hess_ac", got.hess_ac, want.hess_ac);
      compare("hess_bc", got.hess_bc, want.hess_bc);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SHEAR;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] stretch_a = '0, stretch_b = '0, stretch_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] energy, grad_a, grad_b, grad_c;
  logic signed [63:0] hess_aa, hess_bb, hess_cc, hess_ab, hess_ac, hess_bc;

  energy_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  stable_neohookean_stretch_energy uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note(stretch_a, stretch_b, stretch_c);
      if (out_valid && out_ready)
        sb.check('{energy, grad_a, grad_b, grad_c, hess_aa, hess_bb, hess_cc,
                   hess_ab, hess_ac, hess_bc});
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout");
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver side, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    stretch_a <= a;
    stretch_b <= b;
    stretch_c <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    unique case (idx)
      REG_SHEAR:  sb.shear = data;
      REG_VOLUME: sb.volume = data;
      REG_OFFSET: sb.offset = data[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_stretch();
    int k;
    k = $urandom_range(99);
    if (k < 60) return 32'(ONE) + 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
    if (k < 80) return $urandom;
    if (k < 90) return 32'($signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000);
    unique case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'(-ONE);
    endcase
  endfunction

  logic [47:0] mu_set[6] = '{48'd65536, 48'h0000_0003_0000, 48'hFFFF_FFFF_FFFF, 48'd0,
                             48'h0000_0100_8000, 48'd65536};
  logic [47:0] lam_set[6] = '{48'd131072, 48'h0000_0010_0000, 48'hFFFF_FFFF_FFFF, 48'd0,
                              48'h0001_0000_0000, 48'd131072};
  logic [31:0] off_set[6] = '{32'd8388608, 32'h0030_0000, 32'hFFFF_FFFF, 32'd0,
                              32'h0000_0001, 32'd8388608};

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners at reset settings
    send(32'(ONE), 32'(ONE), 32'(ONE));
    send(0, 0, 0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'(ONE));
    send(32'(-ONE), 32'(ONE), 32'(ONE));
    send(32'(-ONE), 32'(-ONE), 32'(-ONE));
    send(32'h0180_0000, 32'h0080_0000, 32'h0100_0000);
    send(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send(32'h1000_0000, 32'h1000_0000, 32'h1000_0000);
    send(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    // Unused index is ignored by the block
    write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_SHEAR, mu_set[ph]);
      write_reg(REG_VOLUME, lam_set[ph]);
      write_reg(REG_OFFSET, {16'd0, off_set[ph]});
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 73 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 73 : (ph % 4 == 3) ? 27 : 0;
      if (ph % 4 == 3) send_idle_pct = 27;
      send(32'(ONE), 32'(ONE), 32'(ONE));
      send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      for (int n = 0; n < 115; n++) begin
        if (ph == 0 && n == 20) hold_left = 300;
        if (ph == 4 && n == 50) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(negedge clk);
        end
        send(pick_stretch(), pick_stretch(), pick_stretch());
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/snh_pkg.sv
design/snh_mul.sv
design/snh_dly.sv
design/stable_neohookean_stretch_energy.sv
tb/stable_neohookean_stretch_energy_test.sv
